// ===== src/per_sensor_moving_average_alarm_core_defines.svh =====
// Assertion macros shared by the sensor average alarm core.
`ifndef PER_SENSOR_MOVING_AVERAGE_ALARM_CORE_DEFINES_SVH
`define PER_SENSOR_MOVING_AVERAGE_ALARM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSMAA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");
`define PSMAA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");
`else
`define PSMAA_ASSERT_NOW(lbl, ante, cons)
`define PSMAA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/psmaa_pkg.sv =====
// Types and constants shared by the sensor average alarm core.
`timescale 1ns / 1ps
package psmaa_pkg;
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	localparam logic REQ_MAP    = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic REG_MAX_TEMP = 1'b0;
	localparam logic REG_MIN_TEMP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MATCH = 4'b0010,
		ST_UPD   = 4'b0100,
		ST_MUL   = 4'b1000
	} state_t;

	typedef struct packed {
		logic        lookup;
		logic        load;
		logic        update;
		logic [15:0] sensor_key;
		logic [15:0] room_id;
		logic [15:0] sample;
		logic [31:0] timestamp;
	} cell_cmd_t;
endpackage

// ===== src/per_sensor_moving_average_alarm_core.sv =====
// Top level of the per-sensor moving average alarm core.
//
// Channel   Handshake              Payload
// request   start, busy            req_type, sensor_key, room_id, sample, timestamp
// result    done (one cycle)       status, out_room_id, average, average_valid,
//                                  too_hot, too_cold, last_time
// config    cfg_we                 cfg_index, cfg_wdata
//
// A map request gives its result in the cycle after the transfer and leaves busy low.
// A sample request for a mapped sensor keeps busy high through the id match, cell
// update and multiply states and gives its result from the multiply state, which
// the registered multiply adds. A sample for an unknown sensor ends after id match.
// Reset clears the table and loads the threshold defaults.
// The result is shown for one cycle and cannot be held off.
`timescale 1ns / 1ps
`include "per_sensor_moving_average_alarm_core_defines.svh"
module per_sensor_moving_average_alarm_core #(
	parameter int ENTRIES = 16,
	parameter int WINDOW  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [15:0]        sensor_key,
	input  logic [15:0]        room_id,
	input  logic signed [15:0] sample,
	input  logic [31:0]        timestamp,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [1:0]         status,
	output logic [15:0]        out_room_id,
	output logic signed [15:0] average,
	output logic               average_valid,
	output logic               too_hot,
	output logic               too_cold,
	output logic [31:0]        last_time
);
	import psmaa_pkg::*;

	localparam int SUM_W = 16 + $clog2(WINDOW);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [15:0]      max_q;
	logic signed [15:0]      min_q;
	logic signed [15:0]      smp_q;
	logic [31:0]             ts_q;
	logic                    accept;
	logic                    full;
	cell_cmd_t               cmd;
	logic [ENTRIES:0]        claim;
	logic [ENTRIES-1:0]      hit_v;
	logic [15:0]             room_v   [ENTRIES];
	logic [31:0]             time_v   [ENTRIES];
	logic signed [SUM_W-1:0] sum_v    [ENTRIES];
	logic [ENTRIES-1:0]      filled_v;
	logic [15:0]             g_room;
	logic [31:0]             g_time;
	logic [SUM_W-1:0]        g_sum;
	logic                    g_filled;
	logic signed [15:0]      avg;
	logic                    hot;
	logic                    cold;

	logic               done_q;
	logic [1:0]         status_q;
	logic [15:0]        room_q;
	logic signed [15:0] average_q;
	logic               avg_valid_q;
	logic               hot_q;
	logic               cold_q;
	logic [31:0]        time_q;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign full   = cnt_q == CNT_W'(ENTRIES);

	assign cmd.lookup     = accept && (req_type == REQ_SAMPLE);
	assign cmd.load       = accept && (req_type == REQ_MAP) && !full;
	assign cmd.update     = (state_q == ST_MATCH) && claim[0];
	assign cmd.sensor_key = sensor_key;
	assign cmd.room_id    = room_id;
	assign cmd.sample     = smp_q;
	assign cmd.timestamp  = ts_q;

	assign claim[ENTRIES] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		psmaa_cell #(
			.WINDOW (WINDOW),
			.SUM_W  (SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.load_sel  (cnt_q == CNT_W'(i)),
			.claim_in  (claim[i+1]),
			.claim_out (claim[i]),
			.hit       (hit_v[i]),
			.room      (room_v[i]),
			.last_time (time_v[i]),
			.sum       (sum_v[i]),
			.filled    (filled_v[i])
		);
	end

	always_comb begin
		g_room   = '0;
		g_time   = '0;
		g_sum    = '0;
		g_filled = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_v[i]) begin
				g_room   = g_room | room_v[i];
				g_time   = g_time | time_v[i];
				g_sum    = g_sum | sum_v[i];
				g_filled = g_filled | filled_v[i];
			end
		end
	end

	psmaa_avg #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_avg (
		.clk      (clk),
		.en       (state_q == ST_UPD),
		.sum      ($signed(g_sum)),
		.max_temp (max_q),
		.min_temp (min_q),
		.average  (avg),
		.too_hot  (hot),
		.too_cold (cold)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
			ts_q  <= timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			max_q       <= 16'sd7680;
			min_q       <= 16'sd2560;
			done_q      <= 1'b0;
			status_q    <= STATUS_OK;
			room_q      <= '0;
			average_q   <= '0;
			avg_valid_q <= 1'b0;
			hot_q       <= 1'b0;
			cold_q      <= 1'b0;
			time_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_TEMP: max_q <= $signed(cfg_wdata);
					REG_MIN_TEMP: min_q <= $signed(cfg_wdata);
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_MAP) begin
							done_q      <= 1'b1;
							status_q    <= full ? STATUS_FULL : STATUS_OK;
							room_q      <= full ? 16'd0 : room_id;
							average_q   <= '0;
							avg_valid_q <= 1'b0;
							hot_q       <= 1'b0;
							cold_q      <= 1'b0;
							time_q      <= '0;
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else begin
							state_q <= ST_MATCH;
						end
					end
				end
				ST_MATCH: begin
					if (claim[0]) begin
						state_q <= ST_UPD;
					end else begin
						done_q      <= 1'b1;
						status_q    <= STATUS_NOT_FOUND;
						room_q      <= '0;
						average_q   <= '0;
						avg_valid_q <= 1'b0;
						hot_q       <= 1'b0;
						cold_q      <= 1'b0;
						time_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_UPD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					done_q      <= 1'b1;
					status_q    <= STATUS_OK;
					room_q      <= g_room;
					average_q   <= g_filled ? avg : 16'sd0;
					avg_valid_q <= g_filled;
					hot_q       <= g_filled && hot;
					cold_q      <= g_filled && cold;
					time_q      <= g_time;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign out_room_id   = room_q;
	assign average       = average_q;
	assign average_valid = avg_valid_q;
	assign too_hot       = hot_q;
	assign too_cold      = cold_q;
	assign last_time     = time_q;

	`PSMAA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(ENTRIES))
	`PSMAA_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE)
	`PSMAA_ASSERT_NEXT(a_map_done, accept && (req_type == REQ_MAP), done_q)
	`PSMAA_ASSERT_NOW(a_hit_single, state_q == ST_UPD, $onehot(hit_v))
endmodule

// ===== src/psmaa_cell.sv =====
// One table entry: sensor id, room, sample shift line and running window sum.
`timescale 1ns / 1ps
module psmaa_cell #(
	parameter int WINDOW = 8,
	parameter int SUM_W  = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  psmaa_pkg::cell_cmd_t    cmd,
	input  logic                    load_sel,
	input  logic                    claim_in,
	output logic                    claim_out,
	output logic                    hit,
	output logic [15:0]             room,
	output logic [31:0]             last_time,
	output logic signed [SUM_W-1:0] sum,
	output logic                    filled
);
	import psmaa_pkg::*;

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic                    valid_q;
	logic                    match_q;
	logic [15:0]             sensor_q;
	logic [15:0]             room_q;
	logic [POS_W-1:0]        pos_q;
	logic                    filled_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [31:0]             time_q;
	logic signed [15:0]      taps_q [WINDOW];

	assign hit       = match_q & ~claim_in;
	assign claim_out = claim_in | match_q;
	assign room      = room_q;
	assign last_time = time_q;
	assign sum       = sum_q;
	assign filled    = filled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				match_q <= valid_q && (sensor_q == cmd.sensor_key);
			end
			if (cmd.load && load_sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_sel) begin
			sensor_q <= cmd.sensor_key;
			room_q   <= cmd.room_id;
			pos_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
			time_q   <= '0;
		end else if (cmd.update && hit) begin
			taps_q[0] <= $signed(cmd.sample);
			for (int k = 1; k < WINDOW; k++) begin
				taps_q[k] <= taps_q[k-1];
			end
			sum_q <= sum_q + SUM_W'($signed(cmd.sample))
				- (filled_q ? SUM_W'(taps_q[WINDOW-1]) : SUM_W'(0));
			if (pos_q == POS_W'(WINDOW - 1)) begin
				pos_q    <= '0;
				filled_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			time_q <= cmd.timestamp;
		end
	end
endmodule

// ===== src/psmaa_avg.sv =====
// Window average by reciprocal multiplication and threshold compare.
`timescale 1ns / 1ps
module psmaa_avg #(
	parameter int WINDOW = 8,
	parameter int SUM_W  = 19
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [SUM_W-1:0] sum,
	input  logic signed [15:0]      max_temp,
	input  logic signed [15:0]      min_temp,
	output logic signed [15:0]      average,
	output logic                    too_hot,
	output logic                    too_cold
);
	localparam int K      = SUM_W + $clog2(WINDOW);
	localparam int PROD_W = SUM_W + K + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [K:0] RECIP = RECIP_L[K:0];

	logic [SUM_W-1:0]  mag;
	logic              neg_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [15:0]       quo;

	assign mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= sum[SUM_W-1];
			prod_s1 <= PROD_W'(mag) * PROD_W'(RECIP);
		end
	end

	assign quo      = prod_s1[K +: 16];
	assign average  = neg_s1 ? $signed(~quo + 16'd1) : $signed(quo);
	assign too_hot  = average > max_temp;
	assign too_cold = average < min_temp;
endmodule
